@@ rtl/mipf_pkg.sv @@
`timescale 1ns / 1ps

package mipf_pkg;

    // register file port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_BOX_X  = 2'd0,
        REG_BOX_Y  = 2'd1,
        REG_BOX_Z  = 2'd2,
        REG_CUTOFF = 2'd3
    } t_reg_idx;

    // diff, fold, abs, square, sum ahead of the root pipeline
    localparam int PRE_SQRT_STAGES = 5;

endpackage

@@ rtl/minimum_image_pair_filter.sv @@
`timescale 1ns / 1ps

// minimum-image pair filter: takes one candidate atom pair per clock on start
// and returns exactly one result, strobed by o_valid; busy stays low, so a
// pair may be issued every cycle, and the receiver must take each result in
// the cycle it is shown since nothing holds it. results come out of the
// square-root pipeline, which resolves one root bit per stage, behind five
// stages of difference, fold, magnitude, square and sum. per axis the
// separation other - center is folded once by the box length, which brings
// it into [-L/2, L/2] when it lies within [-3L/2, 3L/2], and clamped to the
// signed coordinate range; the result carries the folded deltas, the floor
// square root of the squared length and a neighbor flag (indices differ and
// squared length strictly below the squared cutoff). box lengths reset to all
// ones and the cutoff to zero; registers sit at byte addresses 0, 4, 8 and 12
// and are to be written only while no pair is in flight. the squared cutoff
// is registered from the stored cutoff, so it follows each cutoff write.
module minimum_image_pair_filter #(
    parameter int COORD_BITS      = 24,
    parameter int ATOM_INDEX_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mipf_pkg::APB_AW-1:0]  paddr,
    input  logic [mipf_pkg::APB_DW-1:0]  pwdata,
    output logic [mipf_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // request side
    input  logic                         start,
    output logic                         busy,
    input  logic [ATOM_INDEX_BITS-1:0]   i_center_index,
    input  logic [ATOM_INDEX_BITS-1:0]   i_other_index,
    input  logic [COORD_BITS-1:0]        i_center_x,
    input  logic [COORD_BITS-1:0]        i_center_y,
    input  logic [COORD_BITS-1:0]        i_center_z,
    input  logic [COORD_BITS-1:0]        i_other_x,
    input  logic [COORD_BITS-1:0]        i_other_y,
    input  logic [COORD_BITS-1:0]        i_other_z,
    // result side
    output logic                         o_valid,
    output logic [ATOM_INDEX_BITS-1:0]   o_neighbor_index,
    output logic signed [COORD_BITS-1:0] o_delta_x,
    output logic signed [COORD_BITS-1:0] o_delta_y,
    output logic signed [COORD_BITS-1:0] o_delta_z,
    output logic [COORD_BITS-1:0]        o_distance,
    output logic                         o_is_neighbor
);
    import mipf_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int IB    = ATOM_INDEX_BITS;
    localparam int LAT   = PRE_SQRT_STAGES + CB;
    localparam int SIDEW = IB + 3 * CB;
    // squared length needs 2*CB bits: three terms of at most 2^(2CB-2)
    localparam int SUMW  = 2 * CB;
    // the first stage after the sum register is where the cutoff test lands
    localparam int NEAR0 = PRE_SQRT_STAGES + 1;

    logic [CB-1:0]       w_box_x;
    logic [CB-1:0]       w_box_y;
    logic [CB-1:0]       w_box_z;
    logic [SUMW-1:0]     w_cut_sq;

    logic signed [CB-1:0] w_dx;
    logic signed [CB-1:0] w_dy;
    logic signed [CB-1:0] w_dz;
    logic [2*CB-2:0]     w_sq_x;
    logic [2*CB-2:0]     w_sq_y;
    logic [2*CB-2:0]     w_sq_z;
    logic [CB-1:0]       w_root;

    // valid bits travel with the pair through every stage
    logic                r_vld  [1:LAT];
    // index path: other index, index-differ flag, then the side bundle
    logic [IB-1:0]       r_idx  [1:2];
    logic                r_neq  [1:PRE_SQRT_STAGES];
    logic [SIDEW-1:0]    r_side [3:LAT];
    logic [SUMW-1:0]     r_sum;
    logic                r_near [NEAR0:LAT];

    // no backpressure anywhere: a new pair is taken every cycle
    assign busy   = 1'b0;
    assign pready = 1'b1;

    mipf_cfg #(
        .COORD_BITS (CB)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .o_box_x  (w_box_x),
        .o_box_y  (w_box_y),
        .o_box_z  (w_box_z),
        .o_cut_sq (w_cut_sq)
    );

    // stages 1 to 4 per axis: difference, fold and clamp, magnitude, square
    mipf_axis #(.COORD_BITS(CB)) u_axis_x (
        .i_clk   (i_clk),
        .i_from  (i_center_x),
        .i_to    (i_other_x),
        .i_len   (w_box_x),
        .o_delta (w_dx),
        .o_sq    (w_sq_x)
    );

    mipf_axis #(.COORD_BITS(CB)) u_axis_y (
        .i_clk   (i_clk),
        .i_from  (i_center_y),
        .i_to    (i_other_y),
        .i_len   (w_box_y),
        .o_delta (w_dy),
        .o_sq    (w_sq_y)
    );

    mipf_axis #(.COORD_BITS(CB)) u_axis_z (
        .i_clk   (i_clk),
        .i_from  (i_center_z),
        .i_to    (i_other_z),
        .i_len   (w_box_z),
        .o_delta (w_dz),
        .o_sq    (w_sq_z)
    );

    // valid chain, the only state that reset touches here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[1] <= start & ~busy;
            for (int s = 2; s <= LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // payload pipeline, free running since nothing ever stalls
    always_ff @(posedge i_clk) begin
        r_idx[1] <= i_other_index;
        r_idx[2] <= r_idx[1];
        r_neq[1] <= (i_center_index != i_other_index);
        for (int s = 2; s <= PRE_SQRT_STAGES; s++) begin
            r_neq[s] <= r_neq[s-1];
        end
        // folded deltas join the index once they are settled
        r_side[3] <= {r_idx[2], w_dx, w_dy, w_dz};
        for (int s = 4; s <= LAT; s++) begin
            r_side[s] <= r_side[s-1];
        end
        // stage 5: squared length
        r_sum <= {1'b0, w_sq_x} + {1'b0, w_sq_y} + {1'b0, w_sq_z};
        // stage 6: strict cutoff test, zero cutoff never passes
        r_near[NEAR0] <= r_neq[PRE_SQRT_STAGES] & (r_sum < w_cut_sq);
        for (int s = NEAR0 + 1; s <= LAT; s++) begin
            r_near[s] <= r_near[s-1];
        end
    end

    // stages 6 to LAT: floor square root, one bit per stage
    mipf_sqrt #(
        .ROOT_BITS (CB)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_sum),
        .o_root (w_root)
    );

    assign o_valid          = r_vld[LAT];
    assign o_neighbor_index = r_side[LAT][SIDEW-1 -: IB];
    assign o_delta_x        = r_side[LAT][3*CB-1 -: CB];
    assign o_delta_y        = r_side[LAT][2*CB-1 -: CB];
    assign o_delta_z        = r_side[LAT][CB-1:0];
    assign o_distance       = w_root;
    assign o_is_neighbor    = r_near[LAT];

endmodule

@@ rtl/mipf_cfg.sv @@
`timescale 1ns / 1ps

module mipf_cfg #(
    parameter int COORD_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mipf_pkg::APB_AW-1:0] paddr,
    input  logic [mipf_pkg::APB_DW-1:0] pwdata,
    output logic [mipf_pkg::APB_DW-1:0] prdata,
    output logic [COORD_BITS-1:0]       o_box_x,
    output logic [COORD_BITS-1:0]       o_box_y,
    output logic [COORD_BITS-1:0]       o_box_z,
    output logic [2*COORD_BITS-1:0]     o_cut_sq
);
    import mipf_pkg::*;

    logic [COORD_BITS-1:0]   r_box_x;
    logic [COORD_BITS-1:0]   r_box_y;
    logic [COORD_BITS-1:0]   r_box_z;
    logic [COORD_BITS-1:0]   r_cut;
    logic [2*COORD_BITS-1:0] r_cut_sq;
    logic [2*COORD_BITS-1:0] w_cut_prod;
    logic                    w_wr;
    t_reg_idx                w_idx;

    assign w_wr  = psel & penable & pwrite;
    assign w_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x <= '1;
            r_box_y <= '1;
            r_box_z <= '1;
            r_cut   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_BOX_X:  r_box_x <= pwdata[COORD_BITS-1:0];
                REG_BOX_Y:  r_box_y <= pwdata[COORD_BITS-1:0];
                REG_BOX_Z:  r_box_z <= pwdata[COORD_BITS-1:0];
                REG_CUTOFF: r_cut   <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // squared cutoff, registered from the stored cutoff
    assign w_cut_prod = r_cut * r_cut;

    always_ff @(posedge i_clk) begin
        r_cut_sq <= w_cut_prod;
    end

    always_comb begin
        case (w_idx)
            REG_BOX_X:  prdata = APB_DW'(r_box_x);
            REG_BOX_Y:  prdata = APB_DW'(r_box_y);
            REG_BOX_Z:  prdata = APB_DW'(r_box_z);
            REG_CUTOFF: prdata = APB_DW'(r_cut);
            default:    prdata = '0;
        endcase
    end

    assign o_box_x  = r_box_x;
    assign o_box_y  = r_box_y;
    assign o_box_z  = r_box_z;
    assign o_cut_sq = r_cut_sq;

endmodule

@@ rtl/mipf_axis.sv @@
`timescale 1ns / 1ps

module mipf_axis #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic [COORD_BITS-1:0]        i_from,
    input  logic [COORD_BITS-1:0]        i_to,
    input  logic [COORD_BITS-1:0]        i_len,
    output logic signed [COORD_BITS-1:0] o_delta,
    output logic [2*COORD_BITS-2:0]      o_sq
);
    import mipf_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int FW = CB + 3;
    localparam logic signed [FW-1:0] SAT_MAX = {4'b0000, {(CB-1){1'b1}}};
    localparam logic signed [FW-1:0] SAT_MIN = {4'b1111, {(CB-1){1'b0}}};

    logic signed [CB:0]     r_diff;
    logic signed [CB-1:0]   r_delta;
    logic [CB-1:0]          r_abs;
    logic [2*CB-2:0]        r_sq;

    logic signed [FW-1:0]   w_d;
    logic signed [FW-1:0]   w_d2;
    logic signed [FW-1:0]   w_len;
    logic signed [FW-1:0]   w_fold;
    logic signed [FW-1:0]   w_sat;
    logic [CB-1:0]          w_u;
    logic [2*CB-1:0]        w_prod;

    // stage 1: raw separation
    always_ff @(posedge i_clk) begin
        r_diff <= $signed({1'b0, i_to}) - $signed({1'b0, i_from});
    end

    // stage 2: single minimum-image fold, then clamp to the signed range
    always_comb begin
        w_d   = {{2{r_diff[CB]}}, r_diff};
        w_d2  = w_d <<< 1;
        w_len = $signed({3'b000, i_len});
        if (w_d2 > w_len) begin
            w_fold = w_d - w_len;
        end else if (w_d2 < -w_len) begin
            w_fold = w_d + w_len;
        end else begin
            w_fold = w_d;
        end
        if (w_fold > SAT_MAX) begin
            w_sat = SAT_MAX;
        end else if (w_fold < SAT_MIN) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = w_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        r_delta <= w_sat[CB-1:0];
    end

    // stage 3: magnitude, most negative value maps to 2^(CB-1)
    assign w_u = r_delta;

    always_ff @(posedge i_clk) begin
        r_abs <= w_u[CB-1] ? (~w_u + 1'b1) : w_u;
    end

    // stage 4: square
    assign w_prod = r_abs * r_abs;

    always_ff @(posedge i_clk) begin
        r_sq <= w_prod[2*CB-2:0];
    end

    assign o_delta = r_delta;
    assign o_sq    = r_sq;

endmodule

@@ rtl/mipf_sqrt.sv @@
`timescale 1ns / 1ps

module mipf_sqrt #(
    parameter int ROOT_BITS = 24
) (
    input  logic                     i_clk,
    input  logic [2*ROOT_BITS-1:0]   i_rad,
    output logic [ROOT_BITS-1:0]     o_root
);
    import mipf_pkg::*;

    localparam int RB = ROOT_BITS;
    localparam int RW = RB + 2;
    localparam int TW = RB + 4;

    // one result bit per stage, restoring digit recurrence
    logic [2*RB-1:0] r_rad  [0:RB-2];
    logic [RW-1:0]   r_rem  [0:RB-2];
    logic [RB-1:0]   r_root [0:RB-1];

    genvar k;
    generate
        for (k = 0; k < RB; k++) begin : g_step
            logic [2*RB-1:0] w_rad;
            logic [RW-1:0]   w_rem;
            logic [RB-1:0]   w_root;
            logic [TW-1:0]   w_tmp;
            logic [TW-1:0]   w_trial;
            logic            w_ge;

            if (k == 0) begin : g_first
                assign w_rad  = i_rad;
                assign w_rem  = '0;
                assign w_root = '0;
            end else begin : g_next
                assign w_rad  = r_rad[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_root = r_root[k-1];
            end

            assign w_tmp   = {w_rem, w_rad[2*RB-1 -: 2]};
            assign w_trial = {2'b00, w_root, 2'b01};
            assign w_ge    = (w_tmp >= w_trial);

            always_ff @(posedge i_clk) begin
                r_root[k] <= {w_root[RB-2:0], w_ge};
            end

            if (k < RB - 1) begin : g_carry
                logic [TW-1:0] w_diff;
                assign w_diff = w_tmp - w_trial;
                always_ff @(posedge i_clk) begin
                    r_rem[k] <= w_ge ? w_diff[RW-1:0] : w_tmp[RW-1:0];
                    r_rad[k] <= w_rad << 2;
                end
            end
        end
    endgenerate

    assign o_root = r_root[RB-1];

endmodule

@@ rtl/mipf_checker.sv @@
`timescale 1ns / 1ps

module mipf_checker #(
    parameter int COORD_BITS      = 24,
    parameter int ATOM_INDEX_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [ATOM_INDEX_BITS-1:0]   i_center_index,
    input logic [ATOM_INDEX_BITS-1:0]   i_other_index,
    input logic                         o_valid,
    input logic [ATOM_INDEX_BITS-1:0]   o_neighbor_index,
    input logic                         o_is_neighbor
);
    import mipf_pkg::*;

    localparam int LAT = PRE_SQRT_STAGES + COORD_BITS;

    // every result answers a request that was taken at the pipeline input
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start & ~busy, LAT))
        else $error("result without matching request");

    // the index rides through the pipeline with its pair
    a_index_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_neighbor_index == $past(i_other_index, LAT)))
        else $error("neighbor index out of step with its request");

    // a pair with equal indices is never a neighbor
    a_self_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid & o_is_neighbor) |->
        ($past(i_center_index, LAT) != $past(i_other_index, LAT)))
        else $error("self pair flagged as neighbor");

    // busy never rises, so a request can be taken in every cycle
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind minimum_image_pair_filter mipf_checker #(
    .COORD_BITS      (COORD_BITS),
    .ATOM_INDEX_BITS (ATOM_INDEX_BITS)
) u_mipf_checker (.*);
